### src/wmm_pkg.sv
// Shared types and constants for the windowed min / mean smoother.
// No dependencies; imported by every module of the block.
`default_nettype none

package wmm_pkg;

   localparam int unsigned SCORE_BITS = 16;
   localparam int unsigned MAX_HALF_WIDTH_DEFAULT = 8;

   localparam int unsigned MODE_BITS = 2;
   localparam int unsigned HALF_BITS = 4;
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS = 4;

   localparam logic [MODE_BITS-1:0] MODE_PASS = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MIN  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MEAN = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMOOTHING_MODE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_WIDTH     = 1'd1;

   typedef struct packed {
      logic [SCORE_BITS-1:0] raw_score;
      logic                  is_last;
   } req_type;

   typedef struct packed {
      logic [SCORE_BITS-1:0] smoothed_score;
      logic                  last_out;
   } rsp_type;

   // token travelling down the cell chain
   typedef struct packed {
      logic valid;
      logic last;
      logic mean;
   } tok_ctl_type;

endpackage

`default_nettype wire

### src/wmm_cell.sv
// One cell of the window chain: holds one stored score and folds it into
// the passing min / sum token when it lies inside the window. Uses wmm_pkg.
`default_nettype none

module wmm_cell
   import wmm_pkg::*;
#(
   parameter int unsigned CELL_INDEX = 0,
   parameter int unsigned IDX_W = 5,
   parameter int unsigned SUM_W = 21
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  shift_en,
   input  wire logic [SCORE_BITS-1:0] shift_score,
   output logic      [SCORE_BITS-1:0] held_score,
   input  wire tok_ctl_type           prev_ctl,
   input  wire logic [IDX_W-1:0]      prev_top,
   input  wire logic [SUM_W-1:0]      prev_sum,
   input  wire logic [SCORE_BITS-1:0] prev_min,
   output tok_ctl_type                next_ctl,
   output logic      [IDX_W-1:0]      next_top,
   output logic      [SUM_W-1:0]      next_sum,
   output logic      [SCORE_BITS-1:0] next_min
);

   logic [SCORE_BITS-1:0] score_ff, score_in;
   tok_ctl_type           ctl_ff;
   logic [IDX_W-1:0]      top_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SCORE_BITS-1:0] min_ff, min_in;
   logic                  take;

   always_comb begin
      take     = prev_top >= IDX_W'(CELL_INDEX);
      score_in = shift_en ? shift_score : score_ff;
      sum_in   = take ? prev_sum + SUM_W'(score_ff) : prev_sum;
      min_in   = (take && (score_ff < prev_min)) ? score_ff : prev_min;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= prev_ctl;
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      top_ff   <= prev_top;
      sum_ff   <= sum_in;
      min_ff   <= min_in;
   end

   assign held_score = score_ff;
   assign next_ctl   = ctl_ff;
   assign next_top   = top_ff;
   assign next_sum   = sum_ff;
   assign next_min   = min_ff;

endmodule

`default_nettype wire

### src/wmm_mean.sv
// Result stage: divides the window sum by the entry count through a
// reciprocal table and one multiply, or passes the minimum. Uses wmm_pkg.
`default_nettype none

module wmm_mean
   import wmm_pkg::*;
#(
   parameter int unsigned DEPTH = 17,
   parameter int unsigned IDX_W = 5,
   parameter int unsigned SUM_W = 21
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tok_ctl_type           in_ctl,
   input  wire logic [IDX_W-1:0]      in_top,
   input  wire logic [SUM_W-1:0]      in_sum,
   input  wire logic [SCORE_BITS-1:0] in_min,
   output tok_ctl_type                out_ctl,
   output logic      [SCORE_BITS-1:0] out_score
);

   // floor(n / c) == (n * ceil(2^S / c)) >> S for all n below 2^SUM_W
   localparam int unsigned L   = $clog2(DEPTH);
   localparam int unsigned S   = SUM_W + L;
   localparam int unsigned R_W = S + 1;
   localparam int unsigned P_W = SUM_W + R_W;

   logic [R_W-1:0]        recip_tab [DEPTH];
   logic [P_W-1:0]        prod_ff, prod_in;
   logic [SCORE_BITS-1:0] min_ff;
   tok_ctl_type           ctl_ff;

   for (genvar Idx = 0; Idx < DEPTH; Idx++) begin : g_recip
      localparam logic [R_W-1:0] RECIP =
         R_W'(((64'd1 << S) + 64'(Idx)) / 64'(Idx + 1));
      assign recip_tab[Idx] = RECIP;
   end

   assign prod_in = P_W'(in_sum) * P_W'(recip_tab[in_top]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      min_ff  <= in_min;
   end

   assign out_ctl   = ctl_ff;
   assign out_score = ctl_ff.mean ? prod_ff[S +: SCORE_BITS] : min_ff;

endmodule

`default_nettype wire

### src/windowed_min_or_mean_smoother.sv
// Top level of the centred sliding-window min / mean smoother.
// Depends on wmm_pkg, wmm_cell and wmm_mean.
// Usage:
//   req_* carries one score item per handshake, with is_last closing the
//   sequence. rsp_* carries smoothed items, lagging the input by the half
//   width W; the last input flushes every pending item, at most W+1, the
//   final one flagged by last_out. csr_* writes the mode and half width,
//   sampled at the first item of each sequence.
// Timing:
//   An item that yields no result is taken with req_ready staying high. Each
//   result runs one token down the 2*MAX_HALF_WIDTH+1 cells and the multiply
//   stage, and rsp_valid rises once the result from it is registered;
//   req_ready returns the cycle after the result is taken. The last item
//   runs one such pass per result. One item is worked on at a time.
// Reset:
//   Synchronous, active high; clears the counters, mode and half width.
//   The score store needs no clearing.
// Stall:
//   A waiting result holds rsp_data; req_ready stays low until every
//   result of the current item has been taken.
`default_nettype none

module windowed_min_or_mean_smoother
   import wmm_pkg::*;
#(
   parameter int unsigned MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int unsigned DEPTH = 2 * MAX_HALF_WIDTH + 1;
   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned HW_W  = $clog2(MAX_HALF_WIDTH + 1);
   localparam int unsigned SUM_W = SCORE_BITS + $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [MODE_BITS-1:0] csr_mode_ff;
   logic [HALF_BITS-1:0] csr_half_ff;
   logic [CNT_W-1:0]     items_seen_ff, items_seen_in;
   logic                 seq_mean_ff, seq_mean_in;
   logic [HW_W-1:0]      seq_half_ff, seq_half_in;
   logic [HW_W-1:0]      k_ff, k_in;
   logic                 flush_ff, flush_in;
   logic [IDX_W-1:0]     maxtop_ff, maxtop_in;
   logic [IDX_W-1:0]     top_ff, top_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_fire;
   logic                 first;
   logic [HW_W-1:0]      w_new, w_cur, k_first, k_sel, k_dec;
   logic                 mean_cur;
   logic [CNT_W-1:0]     cnt;
   logic [IDX_W-1:0]     maxtop_new;

   tok_ctl_type           ctl_chain [DEPTH+1];
   logic [IDX_W-1:0]      top_chain [DEPTH+1];
   logic [SUM_W-1:0]      sum_chain [DEPTH+1];
   logic [SCORE_BITS-1:0] min_chain [DEPTH+1];
   logic [SCORE_BITS-1:0] held      [DEPTH];

   tok_ctl_type           mean_ctl;
   logic [SCORE_BITS-1:0] mean_score;

   function automatic logic [IDX_W-1:0] min_top(
      input logic [HW_W-1:0]  k,
      input logic [HW_W-1:0]  w,
      input logic [IDX_W-1:0] lim
   );
      logic [CNT_W-1:0] span;
      span = CNT_W'(k) + CNT_W'(w);
      return (span > CNT_W'(lim)) ? lim : IDX_W'(span);
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_mode_ff <= MODE_PASS;
         csr_half_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SMOOTHING_MODE: csr_mode_ff <= csr_wdata[MODE_BITS-1:0];
            CSR_HALF_WIDTH:     csr_half_ff <= csr_wdata[HALF_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      first = (items_seen_ff == '0);
      if (csr_mode_ff == MODE_PASS) begin
         w_new = '0;
      end else if (32'(csr_half_ff) > 32'(MAX_HALF_WIDTH)) begin
         w_new = HW_W'(MAX_HALF_WIDTH);
      end else begin
         w_new = HW_W'(csr_half_ff);
      end
      w_cur      = first ? w_new : seq_half_ff;
      mean_cur   = first ? (csr_mode_ff == MODE_MEAN) : seq_mean_ff;
      cnt        = (items_seen_ff == CNT_W'(DEPTH)) ? items_seen_ff
                                                    : items_seen_ff + CNT_W'(1);
      maxtop_new = IDX_W'(cnt - CNT_W'(1));
      k_first    = (items_seen_ff < CNT_W'(w_cur)) ? HW_W'(items_seen_ff) : w_cur;
      k_sel      = req_data.is_last ? k_first : w_cur;
      k_dec      = k_ff - HW_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      items_seen_in = items_seen_ff;
      seq_mean_in   = seq_mean_ff;
      seq_half_in   = seq_half_ff;
      k_in          = k_ff;
      flush_in      = flush_ff;
      maxtop_in     = maxtop_ff;
      top_in        = top_ff;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               seq_mean_in   = mean_cur;
               seq_half_in   = w_cur;
               maxtop_in     = maxtop_new;
               flush_in      = req_data.is_last;
               k_in          = req_data.is_last ? k_first : '0;
               top_in        = min_top(k_sel, w_cur, maxtop_new);
               items_seen_in = req_data.is_last ? '0 : cnt;
               if (req_data.is_last || (items_seen_ff >= CNT_W'(w_cur))) begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mean_ctl.valid) begin
               rsp_in.smoothed_score = mean_score;
               rsp_in.last_out       = mean_ctl.last;
               state_in              = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               if (k_ff != '0) begin
                  k_in     = k_dec;
                  top_in   = min_top(k_dec, seq_half_ff, maxtop_ff);
                  state_in = ST_ISSUE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         items_seen_ff <= '0;
         seq_mean_ff   <= 1'b0;
         seq_half_ff   <= '0;
         k_ff          <= '0;
         flush_ff      <= 1'b0;
         maxtop_ff     <= '0;
         top_ff        <= '0;
         rsp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         items_seen_ff <= items_seen_in;
         seq_mean_ff   <= seq_mean_in;
         seq_half_ff   <= seq_half_in;
         k_ff          <= k_in;
         flush_ff      <= flush_in;
         maxtop_ff     <= maxtop_in;
         top_ff        <= top_in;
         rsp_ff        <= rsp_in;
      end
   end

   // token entering the chain
   assign ctl_chain[0] = '{valid: (state_ff == ST_ISSUE),
                           last:  flush_ff && (k_ff == '0),
                           mean:  seq_mean_ff};
   assign top_chain[0] = top_ff;
   assign sum_chain[0] = '0;
   assign min_chain[0] = '1;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [SCORE_BITS-1:0] shift_src;
      if (i == 0) begin : g_head
         assign shift_src = req_data.raw_score;
      end else begin : g_body
         assign shift_src = held[i-1];
      end
      wmm_cell #(
         .CELL_INDEX (i),
         .IDX_W      (IDX_W),
         .SUM_W      (SUM_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (req_fire),
         .shift_score (shift_src),
         .held_score  (held[i]),
         .prev_ctl    (ctl_chain[i]),
         .prev_top    (top_chain[i]),
         .prev_sum    (sum_chain[i]),
         .prev_min    (min_chain[i]),
         .next_ctl    (ctl_chain[i+1]),
         .next_top    (top_chain[i+1]),
         .next_sum    (sum_chain[i+1]),
         .next_min    (min_chain[i+1])
      );
   end

   wmm_mean #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .SUM_W (SUM_W)
   ) u_mean (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl_chain[DEPTH]),
      .in_top    (top_chain[DEPTH]),
      .in_sum    (sum_chain[DEPTH]),
      .in_min    (min_chain[DEPTH]),
      .out_ctl   (mean_ctl),
      .out_score (mean_score)
   );

`ifndef SYNTHESIS
   a_token_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      mean_ctl.valid |-> state_ff == ST_WAIT)
      else $error("result token outside wait state");

   a_last_item_issues: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.is_last) |=> state_ff == ST_ISSUE)
      else $error("last item gave no result");

   a_last_out_ends_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_out)
         |=> (req_ready && items_seen_ff == '0))
      else $error("sequence not closed after last_out");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      items_seen_ff <= CNT_W'(DEPTH))
      else $error("items_seen beyond window depth");
`endif

endmodule

`default_nettype wire
